[design/ura_pkg.sv]
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types, constants and helpers for the unsigned-to-radix ASCII core.
// ----------------------------------------------------------------------------
package ura_pkg;

    localparam int VALUE_W        = 32;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;
    localparam int VALUE_BITS_DEF = 32;
    localparam int STEP_BITS      = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_back_state;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + {1'b0, d};
        end
        return CHAR_A + {1'b0, d} - {1'b0, DIGIT_TEN};
    endfunction

endpackage

[design/ura_front.sv]
// ----------------------------------------------------------------------------
// ura_front
// Radix register, input capture and a two-entry job queue toward the back end.
// ----------------------------------------------------------------------------
module ura_front
    import ura_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RADIX_W-1:0] i_cfg_data,
    output t_job               o_job,
    output logic               o_job_valid,
    input  logic               i_job_pop
);

    localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VW);

    logic [RADIX_W-1:0] r_radix;
    t_job               r_q [2];
    logic               r_wr;
    logic               r_rd;
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    logic               push;
    logic               pop;
    t_job               in_job;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_cnt == 2'd2);
    assign push        = i_start && !o_busy;
    assign pop         = i_job_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    assign in_job.value = i_value & VALUE_MASK;
    assign in_job.radix = clamp_radix(r_radix);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= i_cfg_data;
            end
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_job;
        end
    end

endmodule

[design/ura_back.sv]
// ----------------------------------------------------------------------------
// ura_back
// Iterative divide-by-radix unit, digit stack and most-significant-first emitter.
// ----------------------------------------------------------------------------
module ura_back
    import ura_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    localparam int VW      = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int PAD_W   = ((VW + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS   = PAD_W / STEP_BITS;
    localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W   = $clog2(VW);
    localparam int SP_W    = $clog2(VW + 1);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [PAD_W-1:0]   r_num;
    logic [DIGIT_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;
    logic [STEP_CW-1:0] r_step;
    logic [SP_W-1:0]    r_sp;
    logic [DIGIT_W-1:0] r_stack [VW];
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [PAD_W-1:0]   c_num;
    logic [DIGIT_W-1:0] c_rem;
    logic [DIGIT_W:0]   c_rem_ext;
    logic               step_last;
    logic               quo_zero;
    logic [SP_W-1:0]    sp_dec;
    logic               load;
    logic               do_div;
    logic               emit;

    // eight bits of restoring division per cycle; quotient shifts in from the bottom
    always_comb begin
        c_num     = r_num;
        c_rem     = r_rem;
        c_rem_ext = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            c_rem_ext = {c_rem, c_num[PAD_W-1]};
            c_num     = {c_num[PAD_W-2:0], 1'b0};
            if (c_rem_ext >= {1'b0, r_radix}) begin
                c_rem_ext = c_rem_ext - {1'b0, r_radix};
                c_num[0]  = 1'b1;
            end
            c_rem = c_rem_ext[DIGIT_W-1:0];
        end
    end

    assign step_last = (r_step == STEP_CW'(STEPS - 1));
    assign quo_zero  = (c_num == '0);
    assign sp_dec    = r_sp - SP_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (step_last && quo_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_sp == SP_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        load   = 1'b0;
        do_div = 1'b0;
        emit   = 1'b0;
        case (r_state)
            S_IDLE:  load   = i_job_valid;
            S_DIV:   do_div = 1'b1;
            S_EMIT:  emit   = 1'b1;
            default: load   = 1'b0;
        endcase
    end

    assign o_job_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= emit;
            if (load) begin
                r_step <= '0;
                r_sp   <= '0;
            end else if (do_div) begin
                r_step <= step_last ? '0 : r_step + STEP_CW'(1);
                if (step_last) begin
                    r_sp <= r_sp + SP_W'(1);
                end
            end else if (emit) begin
                r_sp <= sp_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_num   <= PAD_W'(i_job.value);
            r_rem   <= '0;
            r_radix <= i_job.radix;
        end else if (do_div) begin
            r_num <= c_num;
            r_rem <= step_last ? '0 : c_rem;
            if (step_last) begin
                r_stack[r_sp[IDX_W-1:0]] <= c_rem;
            end
        end
        if (emit) begin
            r_char <= digit_char(r_stack[sp_dec[IDX_W-1:0]]);
            r_last <= (r_sp == SP_W'(1));
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("strobe without emit");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(VW))
        else $error("digit stack overflow");

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("strobe after last digit");

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_radix >= RADIX_MIN && r_radix <= RADIX_MAX))
        else $error("radix out of range in divider");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_sp != '0))
        else $error("emit with empty stack");

endmodule

[design/unsigned_to_radix_ascii_core.sv]
// ----------------------------------------------------------------------------
// unsigned_to_radix_ascii_core
// Converts unsigned numbers to ASCII digits in a programmable radix.
// ----------------------------------------------------------------------------
// Input: a word is taken on i_start while o_busy is low. A two-entry queue
// holds words ahead of the converter, so o_busy rises only when both are full.
// Config: i_cfg_valid/o_cfg_ready writes the 6-bit radix (reset 10); values
// below 2 act as 2, above 36 as 36. The radix is sampled when a word is taken.
// Output: one character per cycle on o_character with o_valid, most
// significant digit first, o_last on the final digit. There is no backpressure.
// Divider: each digit takes a full restoring division of the remaining
// quotient by the radix, eight quotient bits per cycle; the digits then
// stream out from the stack. The divider handles one word at a time.
// Reset empties the queue, stops any conversion and restores radix 10.
// ----------------------------------------------------------------------------
module unsigned_to_radix_ascii_core
    import ura_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RADIX_W-1:0] i_cfg_data,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_character,
    output logic               o_last
);

    t_job job;
    logic job_valid;
    logic job_pop;

    ura_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    ura_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for unsigned_to_radix_ascii_core. Words are sent on the
// start/busy handshake and the radix is set on the config channel between
// phases. A behavioral converter predicts the digit stream for each word taken,
// and every strobed character is checked against it in order. Directed words
// cover reset radix, binary, clamped radix values and radix 36. Random phases
// then sweep the radix with power-of-radix boundary values, and a final phase
// runs with no sender gaps.
// ----------------------------------------------------------------------------
module testbench;
    import ura_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;
    localparam int TAIL_CYCLES    = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_digit;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [VALUE_W-1:0] i_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [RADIX_W-1:0] i_cfg_data;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;

    t_digit             expected_chars[$];
    t_digit             want;
    logic [RADIX_W-1:0] radix_reg;
    logic               idle_on;
    int                 err_count;
    int                 idle_cycles;

    unsigned_to_radix_ascii_core #(
        .VALUE_BITS(VALUE_BITS_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_value    (i_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_character(o_character),
        .o_last     (o_last)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (err_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h",
                     $time, what, got, exp_val);
        end
        err_count++;
    endtask

    function automatic int unsigned radix_in_use();
        if (radix_reg < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (radix_reg > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return 32'(radix_reg);
    endfunction

    // digits are built least significant first, then queued most significant first
    task automatic push_digits(input logic [VALUE_W-1:0] value);
        logic [CHAR_W-1:0] digits[$];
        longint unsigned   rest;
        int unsigned       base;
        int unsigned       d;
        base = radix_in_use();
        rest = 64'(value) & ((64'd1 << VALUE_BITS_DEF) - 64'd1);
        do begin
            d = 32'(rest % 64'(base));
            if (d < DIGIT_TEN) begin
                digits.push_front(CHAR_ZERO + CHAR_W'(d));
            end else begin
                digits.push_front(CHAR_A + CHAR_W'(d - DIGIT_TEN));
            end
            rest = rest / 64'(base);
        end while (rest != 0);
        foreach (digits[k]) begin
            expected_chars.push_back('{digits[k], k == digits.size() - 1});
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned p;
        int unsigned     base;
        int unsigned     n;
        base = radix_in_use();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, base * base);
            1, 2: begin
                p = 1;
                n = $urandom_range(1, 32);
                repeat (n) begin
                    if (p * base <= 64'hFFFF_FFFF) begin
                        p = p * base;
                    end
                end
                return VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            3: return ~VALUE_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] value);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_value = value;
        do @(posedge i_clk); while (o_busy);
        push_digits(value);
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] radix);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = radix;
        do @(posedge i_clk); while (!o_cfg_ready);
        radix_reg = radix;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_radix();
        send_value('0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd1_000_000_000);
        send_value('1);
    endtask

    task automatic test_binary();
        write_radix(6'd2);
        send_value('0);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value('1);
    endtask

    task automatic test_clamped_radix();
        write_radix('0);
        send_value(32'd5);
        write_radix(6'd1);
        send_value(32'd6);
        write_radix('1);
        send_value('1);
        send_value(32'd1295);
        write_radix(6'd37);
        send_value(32'd36);
    endtask

    task automatic test_high_radix();
        write_radix(6'd36);
        send_value(32'd35);
        send_value(32'd36);
        send_value('1);
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
    endtask

    task automatic test_random_radix();
        for (int phase = 0; phase < 10; phase++) begin
            if ($urandom_range(0, 4) == 0) begin
                write_radix(RADIX_W'($urandom_range(0, 63)));
            end else begin
                write_radix(RADIX_W'($urandom_range(2, 36)));
            end
            repeat (40) send_value(pick_value());
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_radix(RADIX_W'($urandom_range(2, 36)));
        repeat (40) send_value(pick_value());
    endtask

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected word", int'(o_character), 0);
            end else begin
                want = expected_chars.pop_front();
                if (o_character !== want.character) begin
                    report_mismatch("character", int'(o_character), int'(want.character));
                end
                if (o_last !== want.last) begin
                    report_mismatch("last", int'(o_last), int'(want.last));
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        radix_reg   = RADIX_RESET;
        idle_on     = 1'b1;
        err_count   = 0;
        idle_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_radix();
        test_binary();
        test_clamped_radix();
        test_high_radix();
        test_random_radix();
        test_back_to_back();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch("missing words", 0, expected_chars.size());
        end
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
